### rtl/assert_macros.svh
// Assertion macros for the checker file of the lexer block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define TEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define TEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked while reset is held.
`define TEL_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tel_pkg.sv
// Shared types and constants of the expression lexer block.
// No dependencies; imported by every module of the block.
package tel_pkg;

  localparam int LENGTH_BITS = 8;
  localparam int TOKEN_LEN_W = 8;
  localparam int TOKEN_LEN_MAX = (1 << TOKEN_LEN_W) - 1;
  localparam int KIND_W = 4;
  localparam int CHAR_W = 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_ID    = 4'd0,
    KIND_INT   = 4'd1,
    KIND_GT    = 4'd2,
    KIND_GE    = 4'd3,
    KIND_EQ    = 4'd4,
    KIND_LIT   = 4'd5,
    KIND_PLUS  = 4'd6,
    KIND_MINUS = 4'd7,
    KIND_STAR  = 4'd8,
    KIND_SLASH = 4'd9
  } kind_t;

  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // Character class of one request, as decided by the front end.
  typedef struct packed {
    logic flush;
    logic letter;
    logic digit;
    logic ch_i;
    logic ch_n;
    logic ch_t;
    logic ch_gt;
    logic ch_eq;
    logic ch_plus;
    logic ch_minus;
    logic ch_star;
    logic ch_slash;
  } cls_t;

endpackage

### rtl/tel_front.sv
// Front end of the lexer: input handshake and character classification.
// Depends on tel_pkg.
module tel_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [tel_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       q_full,
  output logic                       q_push,
  output tel_pkg::cls_t              q_wdata
);
  import tel_pkg::*;

  logic [CHAR_W-1:0] c;

  assign c        = in_char_code;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata          = '0;
    q_wdata.flush    = in_command;
    q_wdata.letter   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    q_wdata.digit    = (c >= 8'h30 && c <= 8'h39);
    q_wdata.ch_i     = (c == CH_I);
    q_wdata.ch_n     = (c == CH_N);
    q_wdata.ch_t     = (c == CH_T);
    q_wdata.ch_gt    = (c == CH_GT);
    q_wdata.ch_eq    = (c == CH_EQ);
    q_wdata.ch_plus  = (c == CH_PLUS);
    q_wdata.ch_minus = (c == CH_MINUS);
    q_wdata.ch_star  = (c == CH_STAR);
    q_wdata.ch_slash = (c == CH_SLASH);
  end

endmodule

### rtl/tel_queue.sv
// Short request queue between the lexer front end and back end.
// Depends on tel_pkg.
module tel_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tel_pkg::cls_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tel_pkg::cls_t rdata
);
  import tel_pkg::*;

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/tel_back.sv
// Back end of the lexer: token automaton, length counter and result register.
// Depends on tel_pkg.
module tel_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  tel_pkg::cls_t                   q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tel_pkg::KIND_W-1:0]      out_token_kind,
  output logic [tel_pkg::TOKEN_LEN_W-1:0] out_token_length,
  output logic                            out_length_clipped
);
  import tel_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ID, S_I, S_IN, S_INT, S_GT, S_GE, S_EQ,
    S_LIT, S_PLUS, S_MINUS, S_STAR, S_SLASH
  } lex_state_t;

  localparam logic [LENGTH_BITS-1:0] RUN_MAX = {LENGTH_BITS{1'b1}};

  lex_state_t             state_r, state_nxt;
  logic [LENGTH_BITS-1:0] run_r, run_nxt;
  logic                   clip_r, clip_nxt;
  logic                   out_valid_r;
  kind_t                  kind_r;
  logic [TOKEN_LEN_W-1:0] len_r;
  logic                   lclip_r;

  logic       alnum, ext, emit;
  lex_state_t ext_state, start_state;
  kind_t      kind_now;
  logic [31:0] len_ext;
  logic       over;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    alnum     = q_rdata.letter || q_rdata.digit;
    ext       = 1'b0;
    ext_state = state_r;
    case (state_r)
      S_ID: begin
        if (alnum) begin ext = 1'b1; ext_state = S_ID; end
      end
      S_I: begin
        if (q_rdata.ch_n) begin ext = 1'b1; ext_state = S_IN; end
        else if (alnum) begin ext = 1'b1; ext_state = S_ID; end
      end
      S_IN: begin
        if (q_rdata.ch_t) begin ext = 1'b1; ext_state = S_INT; end
        else if (alnum) begin ext = 1'b1; ext_state = S_ID; end
      end
      S_INT: begin
        if (alnum) begin ext = 1'b1; ext_state = S_ID; end
      end
      S_GT: begin
        if (q_rdata.ch_eq) begin ext = 1'b1; ext_state = S_GE; end
      end
      S_LIT: begin
        if (q_rdata.digit) begin ext = 1'b1; ext_state = S_LIT; end
      end
      default: ;
    endcase
    // An end-of-text request never extends the pending token.
    if (q_rdata.flush) begin
      ext = 1'b0;
    end
    emit = !ext && (state_r != S_IDLE);

    if (q_rdata.flush)         start_state = S_IDLE;
    else if (q_rdata.ch_i)     start_state = S_I;
    else if (q_rdata.letter)   start_state = S_ID;
    else if (q_rdata.digit)    start_state = S_LIT;
    else if (q_rdata.ch_gt)    start_state = S_GT;
    else if (q_rdata.ch_eq)    start_state = S_EQ;
    else if (q_rdata.ch_plus)  start_state = S_PLUS;
    else if (q_rdata.ch_minus) start_state = S_MINUS;
    else if (q_rdata.ch_star)  start_state = S_STAR;
    else if (q_rdata.ch_slash) start_state = S_SLASH;
    else                       start_state = S_IDLE;

    if (ext) begin
      state_nxt = ext_state;
      if (run_r == RUN_MAX) begin
        run_nxt  = run_r;
        clip_nxt = 1'b1;
      end else begin
        run_nxt  = run_r + 1'b1;
        clip_nxt = clip_r;
      end
    end else begin
      state_nxt = start_state;
      run_nxt   = (start_state != S_IDLE) ? LENGTH_BITS'(1) : '0;
      clip_nxt  = 1'b0;
    end

    case (state_r)
      S_INT:   kind_now = KIND_INT;
      S_GT:    kind_now = KIND_GT;
      S_GE:    kind_now = KIND_GE;
      S_EQ:    kind_now = KIND_EQ;
      S_LIT:   kind_now = KIND_LIT;
      S_PLUS:  kind_now = KIND_PLUS;
      S_MINUS: kind_now = KIND_MINUS;
      S_STAR:  kind_now = KIND_STAR;
      S_SLASH: kind_now = KIND_SLASH;
      default: kind_now = KIND_ID;
    endcase

    // The length field is narrower than the counter when LENGTH_BITS exceeds it.
    len_ext = 32'(run_r);
    over    = (len_ext > 32'(TOKEN_LEN_MAX));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        state_r <= state_nxt;
        run_r   <= run_nxt;
        clip_r  <= clip_nxt;
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
        kind_r      <= kind_now;
        len_r       <= over ? TOKEN_LEN_W'(TOKEN_LEN_MAX) : len_ext[TOKEN_LEN_W-1:0];
        lclip_r     <= clip_r || over;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_token_kind     = kind_r;
  assign out_token_length   = len_r;
  assign out_length_clipped = lclip_r;

endmodule

### rtl/tiny_expression_lexer_core.sv
// Expression lexer core: one character or end-of-text request per cycle while not stalled.
// A request is held in the request queue, then the automaton registers the token it closes
// in the result register; requests are not popped while a result waits on out_ready.
// Throughput: one request per cycle, bounded by the single-step automaton update.
// Reset (rst_n low, synchronous): automaton idle, counters cleared, queue and result empty.
module tiny_expression_lexer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [tel_pkg::CHAR_W-1:0]      in_char_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tel_pkg::KIND_W-1:0]      out_token_kind,
  output logic [tel_pkg::TOKEN_LEN_W-1:0] out_token_length,
  output logic                            out_length_clipped
);
  import tel_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cls_t q_wdata, q_rdata;

  tel_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  tel_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  tel_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_kind     (out_token_kind),
    .out_token_length   (out_token_length),
    .out_length_clipped (out_length_clipped)
  );

endmodule

### rtl/tel_checker.sv
// Port-level checker for the expression lexer core, bound to the top level.
// Depends on tel_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tel_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_command,
  input logic [tel_pkg::CHAR_W-1:0]      in_char_code,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tel_pkg::KIND_W-1:0]      out_token_kind,
  input logic [tel_pkg::TOKEN_LEN_W-1:0] out_token_length,
  input logic                            out_length_clipped
);
  import tel_pkg::*;

  logic [CHAR_W:0] in_req;

  assign in_req = {in_command, in_char_code};

  `TEL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_req))
  `TEL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_kind))
  `TEL_ASSERT_IMP(a_len_nonzero, out_valid, out_token_length != '0)
  `TEL_ASSERT_IMP(a_clip_sat, out_valid && out_length_clipped, out_token_length == '1)
  `TEL_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind tiny_expression_lexer_core tel_checker u_tel_checker (.*);
